[hdl/ftc_pkg.sv]
// ftc_pkg: types and constants shared by the flow table with counters
// used by ftc_scan and flow_table_with_counters; no dependencies
`default_nettype none

package ftc_pkg;

   localparam int ADDR_W   = 32;
   localparam int PORT_W   = 16;
   localparam int KEY_W    = ADDR_W + PORT_W;
   localparam int COUNT_W  = 32;
   localparam int SLOT_W   = 7;
   localparam int STATUS_W = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // message kind carried on the input tuser
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_KNOWN     = 3'd0,
      ST_NEW       = 3'd1,
      ST_FULL      = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_UNMATCHED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DECIDE
   } state_type;

   // sequencer to compare unit
   typedef struct packed {
      logic start;   // new message, forget earlier findings
      logic valid;   // read data for one slot is on the ram outputs
   } scan_ctl_type;

   // compare unit findings
   typedef struct packed {
      logic hit;     // a live slot with the same key was seen
      logic free;    // a free slot was seen
   } scan_flags_type;

endpackage

`default_nettype wire

[hdl/ftc_ram.sv]
// ftc_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ftc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hdl/ftc_scan.sv]
// ftc_scan: shared key compare unit, walks one slot per cycle and keeps the
// lowest live match and the lowest free slot; uses ftc_pkg
`default_nettype none

module ftc_scan #(
   parameter int SLOTS = 128
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ftc_pkg::scan_ctl_type         ctl,
   input  wire logic [$clog2(SLOTS)-1:0]      idx,
   input  wire logic [ftc_pkg::KEY_W-1:0]     key_rd,
   input  wire logic [ftc_pkg::COUNT_W-1:0]   cnt_rd,
   input  wire logic [ftc_pkg::KEY_W-1:0]     key_req,
   output ftc_pkg::scan_flags_type            flags,
   output logic      [$clog2(SLOTS)-1:0]      hit_idx,
   output logic      [ftc_pkg::COUNT_W-1:0]   hit_cnt,
   output logic      [$clog2(SLOTS)-1:0]      free_idx
);

   localparam int IW = $clog2(SLOTS);

   ftc_pkg::scan_flags_type flags_ff, flags_in;
   logic [IW-1:0]               hit_idx_ff, hit_idx_in;
   logic [ftc_pkg::COUNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [IW-1:0]               free_idx_ff, free_idx_in;
   logic                        empty;
   logic                        match;

   always_comb begin
      empty       = (cnt_rd == '0);
      match       = !empty && (key_rd == key_req);
      flags_in    = flags_ff;
      hit_idx_in  = hit_idx_ff;
      hit_cnt_in  = hit_cnt_ff;
      free_idx_in = free_idx_ff;
      if (ctl.start) begin
         flags_in = '0;
      end else if (ctl.valid) begin
         // slots arrive in ascending order, so the first find is the lowest
         if (match && !flags_ff.hit) begin
            flags_in.hit = 1'b1;
            hit_idx_in   = idx;
            hit_cnt_in   = cnt_rd;
         end
         if (empty && !flags_ff.free) begin
            flags_in.free = 1'b1;
            free_idx_in   = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      hit_idx_ff  <= hit_idx_in;
      hit_cnt_ff  <= hit_cnt_in;
      free_idx_ff <= free_idx_in;
   end

   assign flags    = flags_ff;
   assign hit_idx  = hit_idx_ff;
   assign hit_cnt  = hit_cnt_ff;
   assign free_idx = free_idx_ff;

endmodule

`default_nettype wire

[hdl/flow_table_with_counters.sv]
// flow_table_with_counters: flow table keyed by source address and port with
// per-flow message counters; uses ftc_pkg, ftc_ram and ftc_scan
//
//   channel | dir | ports                         | contents
//   --------+-----+-------------------------------+---------------------------------
//   req     | in  | tvalid tready tdata[47:0] tuser | message key, kind
//   rsp     | out | tvalid tready tdata[39:0] tuser | count and slot, status
//
// - after reset a clearing pass zeroes the count ram, one slot a cycle;
//   req_tready stays low until it ends
// - the walk reads one slot per cycle through the single ram read port; the
//   next message is taken only once the last one has been decided
// - a result waits in the output register; the next message is taken and
//   walked meanwhile, and only the final decide step waits on rsp_tready
`default_nettype none

module flow_table_with_counters #(
   parameter int SLOTS = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // src_addr[31:0], src_port[47:32]
   input  wire logic        req_tuser,   // kind[0]
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,   // count[31:0], slot[38:32], zero[39]
   output logic      [2:0]  rsp_tuser    // status[2:0]
);

   localparam int IW = $clog2(SLOTS);   // slot index width
   localparam int CW = IW + 1;          // walk counter, holds SLOTS itself
   localparam int KW = ftc_pkg::KEY_W;
   localparam int NW = ftc_pkg::COUNT_W;

   // state and walk sequencing
   ftc_pkg::state_type state_ff, state_in;
   logic [CW-1:0] iss_ff, iss_in;            // next slot to read, or clear pointer
   logic          pend_ff, pend_in;          // read data of one slot due this cycle
   logic [IW-1:0] pend_idx_ff, pend_idx_in;

   // message held during the walk
   logic          kind_ff, kind_in;
   logic [KW-1:0] key_ff, key_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   ftc_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [NW-1:0]           rsp_count_ff, rsp_count_in;
   logic [ftc_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // ram ports
   logic          cnt_we;
   logic          key_we;
   logic [IW-1:0] wr_addr;
   logic [NW-1:0] cnt_wdata;
   logic [IW-1:0] rd_addr;
   logic [NW-1:0] cnt_rd;
   logic [KW-1:0] key_rd;

   // compare unit
   ftc_pkg::scan_ctl_type   scan_ctl;
   ftc_pkg::scan_flags_type scan_flags;
   logic [IW-1:0] hit_idx;
   logic [NW-1:0] hit_cnt;
   logic [IW-1:0] free_idx;

   logic req_xfer;
   logic rsp_free;

   // slot field carries the low bits of the index, zero filled for small tables
   function automatic logic [ftc_pkg::SLOT_W-1:0] slot_field(input logic [IW-1:0] idx);
      logic [IW+ftc_pkg::SLOT_W-1:0] ext;
      ext = {{ftc_pkg::SLOT_W{1'b0}}, idx};
      return ext[ftc_pkg::SLOT_W-1:0];
   endfunction

   ftc_ram #(
      .WIDTH (NW),
      .DEPTH (SLOTS)
   ) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (wr_addr),
      .wdata (cnt_wdata),
      .raddr (rd_addr),
      .rdata (cnt_rd)
   );

   // key store is never cleared: a key is only looked at while its count is live
   ftc_ram #(
      .WIDTH (KW),
      .DEPTH (SLOTS)
   ) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (wr_addr),
      .wdata (key_ff),
      .raddr (rd_addr),
      .rdata (key_rd)
   );

   ftc_scan #(
      .SLOTS (SLOTS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .idx      (pend_idx_ff),
      .key_rd   (key_rd),
      .cnt_rd   (cnt_rd),
      .key_req  (key_ff),
      .flags    (scan_flags),
      .hit_idx  (hit_idx),
      .hit_cnt  (hit_cnt),
      .free_idx (free_idx)
   );

   assign req_tready = (state_ff == ftc_pkg::S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      iss_in        = iss_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_slot_in   = rsp_slot_ff;
      cnt_we        = 1'b0;
      key_we        = 1'b0;
      wr_addr       = iss_ff[IW-1:0];
      cnt_wdata     = '0;
      rd_addr       = '0;
      scan_ctl.start = 1'b0;
      scan_ctl.valid = pend_ff;

      case (state_ff)
         ftc_pkg::S_CLEAR: begin
            // one count entry zeroed per cycle
            cnt_we = 1'b1;
            if (iss_ff == CW'(SLOTS - 1)) begin
               iss_in   = '0;
               state_in = ftc_pkg::S_IDLE;
            end else begin
               iss_in = iss_ff + CW'(1);
            end
         end
         ftc_pkg::S_IDLE: begin
            if (req_xfer) begin
               kind_in        = req_tuser;
               key_in         = {req_tdata[47:32], req_tdata[31:0]};
               iss_in         = '0;
               scan_ctl.start = 1'b1;
               state_in       = ftc_pkg::S_SCAN;
            end
         end
         ftc_pkg::S_SCAN: begin
            // issue one read per cycle, the compare of each slot lands in the cycle after its read
            if (iss_ff != CW'(SLOTS)) begin
               rd_addr     = iss_ff[IW-1:0];
               pend_in     = 1'b1;
               pend_idx_in = iss_ff[IW-1:0];
               iss_in      = iss_ff + CW'(1);
            end else if (!pend_ff) begin
               state_in = ftc_pkg::S_DECIDE;
            end
         end
         ftc_pkg::S_DECIDE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ftc_pkg::S_IDLE;
               if (kind_ff == ftc_pkg::KIND_CLOSE) begin
                  if (scan_flags.hit) begin
                     // free the slot: a zero count marks it unused
                     cnt_we        = 1'b1;
                     wr_addr       = hit_idx;
                     cnt_wdata     = '0;
                     rsp_status_in = ftc_pkg::ST_REMOVED;
                     rsp_count_in  = hit_cnt;
                     rsp_slot_in   = slot_field(hit_idx);
                  end else begin
                     rsp_status_in = ftc_pkg::ST_UNMATCHED;
                     rsp_count_in  = '0;
                     rsp_slot_in   = '0;
                  end
               end else if (scan_flags.hit) begin
                  // known flow: echo the count, then bump it unless saturated
                  cnt_we        = 1'b1;
                  wr_addr       = hit_idx;
                  cnt_wdata     = (hit_cnt == ftc_pkg::COUNT_MAX) ? hit_cnt
                                                                 : hit_cnt + NW'(1);
                  rsp_status_in = ftc_pkg::ST_KNOWN;
                  rsp_count_in  = hit_cnt;
                  rsp_slot_in   = slot_field(hit_idx);
               end else if (scan_flags.free) begin
                  // new flow: claimed with count 1, echoed, left at 2
                  cnt_we        = 1'b1;
                  key_we        = 1'b1;
                  wr_addr       = free_idx;
                  cnt_wdata     = NW'(2);
                  rsp_status_in = ftc_pkg::ST_NEW;
                  rsp_count_in  = NW'(1);
                  rsp_slot_in   = slot_field(free_idx);
               end else begin
                  // table full, message dropped
                  rsp_status_in = ftc_pkg::ST_FULL;
                  rsp_count_in  = '0;
                  rsp_slot_in   = '0;
               end
            end
         end
         default: begin
            state_in = ftc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ftc_pkg::S_CLEAR;
         iss_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_idx_ff   <= pend_idx_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_slot_ff, rsp_count_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire
